// ===== hdl/obb2d_sat_intersect_defines.svh =====
// Assertion macros shared by the oriented box intersection block.
`ifndef OBB2D_SAT_INTERSECT_DEFINES_SVH
`define OBB2D_SAT_INTERSECT_DEFINES_SVH

// Same-cycle implication, sampled on the rising edge, off while reset is high.
`define OBBSAT_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising edge, off while reset is high.
`define OBBSAT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/obbsat_pkg.sv =====
// Constants and the CORDIC angle table for the oriented box intersection block.
package obbsat_pkg;

  localparam int COORD_W            = 32;
  localparam int HALF_W             = 31;
  localparam int ANGLE_BITS_DEF     = 16;
  localparam int TRIG_FRAC_BITS_DEF = 15;
  localparam int PHASE_W            = 32;
  localparam int CORDIC_STEPS       = 30;
  localparam int CORDIC_LAT         = CORDIC_STEPS + 2;
  localparam int NUM_AXES           = 4;
  localparam int GEO_STAGES         = 4;
  localparam logic [31:0] GAIN_Q30  = 32'd652032874;

  // atan(2^-i) as a fraction of a full turn, 2^32 = full turn
  function automatic logic [31:0] atan_entry(input logic [4:0] idx);
    logic [31:0] r;
    case (idx)
      5'd0:  r = 32'h20000000;
      5'd1:  r = 32'h12E4051D;
      5'd2:  r = 32'h09FB385B;
      5'd3:  r = 32'h051111D4;
      5'd4:  r = 32'h028B0D43;
      5'd5:  r = 32'h0145D7E1;
      5'd6:  r = 32'h00A2F61E;
      5'd7:  r = 32'h00517C55;
      5'd8:  r = 32'h0028BE53;
      5'd9:  r = 32'h00145F2F;
      5'd10: r = 32'h000A2F98;
      5'd11: r = 32'h000517CC;
      5'd12: r = 32'h00028BE6;
      5'd13: r = 32'h000145F3;
      5'd14: r = 32'h0000A2F9;
      5'd15: r = 32'h0000517C;
      5'd16: r = 32'h000028BE;
      5'd17: r = 32'h0000145F;
      5'd18: r = 32'h00000A2F;
      5'd19: r = 32'h00000517;
      5'd20: r = 32'h0000028B;
      5'd21: r = 32'h00000145;
      5'd22: r = 32'h000000A2;
      5'd23: r = 32'h00000051;
      5'd24: r = 32'h00000028;
      5'd25: r = 32'h00000014;
      5'd26: r = 32'h0000000A;
      5'd27: r = 32'h00000005;
      5'd28: r = 32'h00000002;
      5'd29: r = 32'h00000001;
      default: r = 32'h00000000;
    endcase
    return r;
  endfunction

endpackage

// ===== hdl/obb2d_sat_intersect.sv =====
// Top level: separating axis overlap test for two 2D oriented boxes.
// Usage:
//   Present one box pair per item on the input channel (in_valid/in_stall):
//   centers signed Q16.16, half extents unsigned Q15.16, angles as a
//   fraction of a full turn. One item leaves on the output channel
//   (out_valid/out_stall) carrying overlap = 1 when the projections meet
//   on all four box axes; touching intervals count as overlap.
// Pipeline: the pipelined CORDIC (one rotation per stage) plus four
//   geometry stages.
// Throughput: one item per cycle when not stalled; all stages are registers.
// Reset (rst, synchronous): clears all stage valid bits, so nothing
//   leaves until new items arrive. The data registers are not reset.
// Stall: when the output holds a valid item and out_stall is high, the
//   whole pipeline freezes and in_stall rises; bubbles are kept, nothing
//   is dropped or repeated.
// Each box interval on an axis d is P +/- R with P = center.d and
// R = |hw*(c,s).d| + |hh*(-s,c).d|; no gap means |PB-PA| <= RA + RB.
`include "obb2d_sat_intersect_defines.svh"

module obb2d_sat_intersect #(
  parameter int ANGLE_BITS     = obbsat_pkg::ANGLE_BITS_DEF,
  parameter int TRIG_FRAC_BITS = obbsat_pkg::TRIG_FRAC_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic signed [31:0]    a_center_x,
  input  logic signed [31:0]    a_center_y,
  input  logic [30:0]           a_half_w,
  input  logic [30:0]           a_half_h,
  input  logic [ANGLE_BITS-1:0] a_angle,
  input  logic signed [31:0]    b_center_x,
  input  logic signed [31:0]    b_center_y,
  input  logic [30:0]           b_half_w,
  input  logic [30:0]           b_half_h,
  input  logic [ANGLE_BITS-1:0] b_angle,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  overlap
);

  localparam int CW_  = obbsat_pkg::COORD_W;
  localparam int HW_  = obbsat_pkg::HALF_W;
  localparam int CL   = obbsat_pkg::CORDIC_LAT;
  localparam int LAT  = CL + obbsat_pkg::GEO_STAGES;
  localparam int NA   = obbsat_pkg::NUM_AXES;
  localparam int T    = TRIG_FRAC_BITS;
  localparam int TW   = T + 1;
  localparam int DW   = CW_ + 1;           // center difference
  localparam int MW   = 2 * T + 3;         // dot of two unit vectors
  localparam int H    = (MW + 1) / 2;      // low split of magnitude
  localparam int HI   = MW - H;
  localparam int PLW  = HW_ + H;
  localparam int PHW  = HW_ + HI;
  localparam int PW   = DW + TW + 1;       // center projection
  localparam int RW   = HW_ + MW + 2;      // one box radius
  localparam int KW   = 2 * T + 37;        // compare width
  localparam int SW   = 4 * CW_ + 4 * HW_;

  logic adv;
  logic in_acc;
  logic [LAT-1:0] vld;

  // side data rides beside the CORDIC
  logic [SW-1:0] dly [CL];
  logic signed [TW-1:0] cos_a, sin_a, cos_b, sin_b;

  logic signed [CW_-1:0] d_acx, d_acy, d_bcx, d_bcy;
  logic [HW_-1:0] d_ahw, d_ahh, d_bhw, d_bhh;

  // stage 1
  logic signed [DW-1:0] g1_dcx, g1_dcy;
  logic signed [TW-1:0] g1_dx [NA];
  logic signed [TW-1:0] g1_dy [NA];
  logic signed [MW-1:0] g1_e  [NA][2][2];
  logic [HW_-1:0]       g1_ext [2][2];
  logic signed [TW-1:0] dir_x_next [NA];
  logic signed [TW-1:0] dir_y_next [NA];
  logic signed [TW-1:0] bc [2];
  logic signed [TW-1:0] bs [2];

  // stage 2
  logic signed [PW-1:0] g2_pc [NA];
  logic [PLW-1:0]       g2_pl [NA][2][2];
  logic [PHW-1:0]       g2_ph [NA][2][2];
  logic [MW-1:0]        mag_next [NA][2][2];

  // stage 3
  logic [PW-1:0] g3_ap [NA];
  logic [RW-1:0] g3_r  [NA][2];

  // stage 4
  logic [NA-1:0] hit_next;

  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;
  assign in_acc   = in_valid && adv;
  assign out_valid = vld[LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[LAT-2:0], in_valid};
    end
  end

  obbsat_cordic #(.ANGLE_BITS(ANGLE_BITS), .TRIG_FRAC_BITS(TRIG_FRAC_BITS)) u_trig_a (
    .clk(clk), .adv(adv), .angle(a_angle), .cos_q(cos_a), .sin_q(sin_a)
  );

  obbsat_cordic #(.ANGLE_BITS(ANGLE_BITS), .TRIG_FRAC_BITS(TRIG_FRAC_BITS)) u_trig_b (
    .clk(clk), .adv(adv), .angle(b_angle), .cos_q(cos_b), .sin_q(sin_b)
  );

  always_ff @(posedge clk) begin
    if (adv) begin
      dly[0] <= {a_center_x, a_center_y, a_half_w, a_half_h,
                 b_center_x, b_center_y, b_half_w, b_half_h};
    end
  end

  for (genvar i = 1; i < CL; i++) begin : g_dly
    always_ff @(posedge clk) begin
      if (adv) begin
        dly[i] <= dly[i-1];
      end
    end
  end

  assign {d_acx, d_acy, d_ahw, d_ahh, d_bcx, d_bcy, d_bhw, d_bhh} = dly[CL-1];

  // Stage 1: center difference, axis directions, box axis dot products
  always_comb begin
    bc[0] = cos_a;
    bs[0] = sin_a;
    bc[1] = cos_b;
    bs[1] = sin_b;
    dir_x_next[0] = cos_a;  dir_y_next[0] = sin_a;
    dir_x_next[1] = -sin_a; dir_y_next[1] = cos_a;
    dir_x_next[2] = cos_b;  dir_y_next[2] = sin_b;
    dir_x_next[3] = -sin_b; dir_y_next[3] = cos_b;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      g1_dcx <= DW'(d_bcx) - DW'(d_acx);
      g1_dcy <= DW'(d_bcy) - DW'(d_acy);
      g1_ext[0][0] <= d_ahw;
      g1_ext[0][1] <= d_ahh;
      g1_ext[1][0] <= d_bhw;
      g1_ext[1][1] <= d_bhh;
      for (int k = 0; k < NA; k++) begin
        g1_dx[k] <= dir_x_next[k];
        g1_dy[k] <= dir_y_next[k];
        for (int b = 0; b < 2; b++) begin
          g1_e[k][b][0] <= MW'(bc[b]) * MW'(dir_x_next[k])
                         + MW'(bs[b]) * MW'(dir_y_next[k]);
          g1_e[k][b][1] <= MW'(bc[b]) * MW'(dir_y_next[k])
                         - MW'(bs[b]) * MW'(dir_x_next[k]);
        end
      end
    end
  end

  // Stage 2: center projection, extent times split dot magnitude
  always_comb begin
    for (int k = 0; k < NA; k++) begin
      for (int b = 0; b < 2; b++) begin
        for (int j = 0; j < 2; j++) begin
          mag_next[k][b][j] = g1_e[k][b][j][MW-1] ? MW'(-g1_e[k][b][j])
                                                  : MW'(g1_e[k][b][j]);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < NA; k++) begin
        g2_pc[k] <= PW'(g1_dcx) * PW'(g1_dx[k]) + PW'(g1_dcy) * PW'(g1_dy[k]);
        for (int b = 0; b < 2; b++) begin
          for (int j = 0; j < 2; j++) begin
            g2_pl[k][b][j] <= PLW'(g1_ext[b][j]) * PLW'(mag_next[k][b][j][H-1:0]);
            g2_ph[k][b][j] <= PHW'(g1_ext[b][j]) * PHW'(mag_next[k][b][j][MW-1:H]);
          end
        end
      end
    end
  end

  // Stage 3: absolute center distance, box radii
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < NA; k++) begin
        g3_ap[k] <= g2_pc[k][PW-1] ? PW'(-g2_pc[k]) : PW'(g2_pc[k]);
        for (int b = 0; b < 2; b++) begin
          g3_r[k][b] <= RW'(g2_pl[k][b][0]) + (RW'(g2_ph[k][b][0]) << H)
                      + RW'(g2_pl[k][b][1]) + (RW'(g2_ph[k][b][1]) << H);
        end
      end
    end
  end

  // Stage 4: no gap on an axis when the distance fits within the sum of both radii
  always_comb begin
    for (int k = 0; k < NA; k++) begin
      hit_next[k] = (KW'(g3_ap[k]) << T) <= (KW'(g3_r[k][0]) + KW'(g3_r[k][1]));
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      overlap <= &hit_next;
    end
  end

  `OBBSAT_ASSERT_NOW(a_stall_hold, clk, rst, out_valid && out_stall, !in_acc,
    "item accepted while the output is held")
  `OBBSAT_ASSERT_NEXT(a_freeze, clk, rst, !adv, $stable(vld),
    "stage valid bits moved during a stall")
  `OBBSAT_ASSERT_NEXT(a_reset_empty, clk, 1'b0, rst, !out_valid,
    "output valid right after reset")

endmodule

// ===== hdl/obbsat_cordic.sv =====
// Pipelined CORDIC sine and cosine, one rotation step per register stage.
module obbsat_cordic #(
  parameter int ANGLE_BITS     = obbsat_pkg::ANGLE_BITS_DEF,
  parameter int TRIG_FRAC_BITS = obbsat_pkg::TRIG_FRAC_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        adv,
  input  logic [ANGLE_BITS-1:0]       angle,
  output logic signed [TRIG_FRAC_BITS:0] cos_q,
  output logic signed [TRIG_FRAC_BITS:0] sin_q
);

  localparam int N   = obbsat_pkg::CORDIC_STEPS;
  localparam int XW  = 34;
  localparam int ZW  = 32;
  localparam int TW  = TRIG_FRAC_BITS + 1;
  localparam int SH  = 30 - TRIG_FRAC_BITS;
  localparam longint RND = (SH > 0) ? (longint'(1) << (SH - 1)) : 0;
  localparam longint LIM = (longint'(1) << TRIG_FRAC_BITS) - 1;

  logic signed [XW-1:0] xs [N+1];
  logic signed [XW-1:0] ys [N+1];
  logic signed [ZW-1:0] zs [N+1];
  logic [1:0]           qs [N+1];
  logic [obbsat_pkg::PHASE_W-1:0] phase;
  logic signed [TW-1:0] cc;
  logic signed [TW-1:0] ss;

  function automatic logic signed [TW-1:0] round_trig(input logic signed [XW-1:0] v);
    logic [XW:0] m;
    m = {1'b0, (v[XW-1] ? -v : v)};
    m = (m + (XW+1)'(RND)) >> SH;
    if (m > (XW+1)'(LIM)) begin
      m = (XW+1)'(LIM);
    end
    return v[XW-1] ? -TW'(m) : TW'(m);
  endfunction

  assign phase = {angle, (obbsat_pkg::PHASE_W - ANGLE_BITS)'(0)};

  always_ff @(posedge clk) begin
    if (adv) begin
      xs[0] <= XW'(obbsat_pkg::GAIN_Q30);
      ys[0] <= '0;
      zs[0] <= ZW'({2'b00, phase[obbsat_pkg::PHASE_W-3:0]});
      qs[0] <= phase[obbsat_pkg::PHASE_W-1:obbsat_pkg::PHASE_W-2];
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_step
    always_ff @(posedge clk) begin
      if (adv) begin
        if (!zs[i][ZW-1]) begin
          xs[i+1] <= xs[i] - (ys[i] >>> i);
          ys[i+1] <= ys[i] + (xs[i] >>> i);
          zs[i+1] <= zs[i] - ZW'(obbsat_pkg::atan_entry(5'(i)));
        end else begin
          xs[i+1] <= xs[i] + (ys[i] >>> i);
          ys[i+1] <= ys[i] - (xs[i] >>> i);
          zs[i+1] <= zs[i] + ZW'(obbsat_pkg::atan_entry(5'(i)));
        end
        qs[i+1] <= qs[i];
      end
    end
  end

  assign cc = round_trig(xs[N]);
  assign ss = round_trig(ys[N]);

  // fold the quadrant back in by swap and negate
  always_ff @(posedge clk) begin
    if (adv) begin
      unique case (qs[N])
        2'd0: begin cos_q <= cc;  sin_q <= ss;  end
        2'd1: begin cos_q <= -ss; sin_q <= cc;  end
        2'd2: begin cos_q <= -cc; sin_q <= -ss; end
        default: begin cos_q <= ss; sin_q <= -cc; end
      endcase
    end
  end

endmodule

// ===== bench/obb2d_sat_intersect_tb.sv =====
// Self-checking testbench for the 2D oriented box separating axis test.
`timescale 1ns / 100ps

module obb2d_sat_intersect_tb;

  typedef struct packed {
    logic signed [obbsat_pkg::COORD_W-1:0] acx, acy;
    logic [obbsat_pkg::HALF_W-1:0] ahw, ahh;
    logic [15:0] aang;
    logic signed [obbsat_pkg::COORD_W-1:0] bcx, bcy;
    logic [obbsat_pkg::HALF_W-1:0] bhw, bhh;
    logic [15:0] bang;
  } box_pair_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic out_valid;
  logic out_stall = 1'b0;
  logic overlap;
  box_pair_t cur = '0;

  box_pair_t pair_q[$];     // items waiting to be driven
  bit hit_q[$];             // predicted overlap flags, oldest first
  int errors = 0;
  int cyc = 0;

  obb2d_sat_intersect dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .a_center_x(cur.acx), .a_center_y(cur.acy),
    .a_half_w(cur.ahw), .a_half_h(cur.ahh), .a_angle(cur.aang),
    .b_center_x(cur.bcx), .b_center_y(cur.bcy),
    .b_half_w(cur.bhw), .b_half_h(cur.bhh), .b_angle(cur.bang),
    .out_valid(out_valid), .out_stall(out_stall), .overlap(overlap)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // CORDIC sine/cosine at Q1.15 with the quadrant folded in afterward.
  function automatic void sin_cos(input logic [15:0] ang, output longint c, output longint s);
    logic [31:0] ph;
    longint x, y, z, nx, cc, ss, m;
    longint r[2];
    ph = {ang, 16'd0};
    z = longint'(ph[29:0]);
    x = longint'(obbsat_pkg::GAIN_Q30);
    y = 0;
    for (int i = 0; i < obbsat_pkg::CORDIC_STEPS; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        y = y + (x >>> i);
        z = z - longint'(obbsat_pkg::atan_entry(5'(i)));
      end else begin
        nx = x + (y >>> i);
        y = y - (x >>> i);
        z = z + longint'(obbsat_pkg::atan_entry(5'(i)));
      end
      x = nx;
    end
    r[0] = x;
    r[1] = y;
    // round half away from zero, then clamp magnitude to full scale minus one lsb
    for (int k = 0; k < 2; k++) begin
      m = (r[k] < 0) ? -r[k] : r[k];
      m = (m + (64'sd1 <<< 14)) >>> 15;
      if (m > 32767) m = 32767;
      r[k] = (r[k] < 0) ? -m : m;
    end
    cc = r[0];
    ss = r[1];
    case (ph[31:30])
      2'd0: begin c = cc;  s = ss;  end
      2'd1: begin c = -ss; s = cc;  end
      2'd2: begin c = -cc; s = -ss; end
      default: begin c = ss; s = -cc; end
    endcase
  endfunction

  // Corners at scale 2^31, in order (-r-u), (+r-u), (+r+u), (-r+u).
  function automatic void corners(input logic signed [31:0] cxi, input logic signed [31:0] cyi,
                                  input logic [30:0] hwi, input logic [30:0] hhi,
                                  input longint c, input longint s,
                                  output longint kx[4], output longint ky[4]);
    longint cx, cy, hw, hh, rx, ry, ux, uy;
    cx = longint'(cxi) * 32768;
    cy = longint'(cyi) * 32768;
    hw = longint'(hwi);
    hh = longint'(hhi);
    rx = hw * c;  ry = hw * s;
    ux = -hh * s; uy = hh * c;
    kx[0] = cx - rx - ux; ky[0] = cy - ry - uy;
    kx[1] = cx + rx - ux; ky[1] = cy + ry - uy;
    kx[2] = cx + rx + ux; ky[2] = cy + ry + uy;
    kx[3] = cx - rx + ux; ky[3] = cy - ry + uy;
  endfunction

  function automatic void interval(input longint kx[4], input longint ky[4],
                                   input longint dx, input longint dy,
                                   output logic signed [127:0] lo, output logic signed [127:0] hi);
    logic signed [127:0] p, wx, wy, wdx, wdy;
    for (int i = 0; i < 4; i++) begin
      wx = kx[i]; wy = ky[i]; wdx = dx; wdy = dy;
      p = wx * wdx + wy * wdy;
      if (i == 0 || p < lo) lo = p;
      if (i == 0 || p > hi) hi = p;
    end
  endfunction

  function automatic bit boxes_overlap(input box_pair_t p);
    longint ca, sa, cb, sb;
    longint kax[4], kay[4], kbx[4], kby[4];
    longint dx[4], dy[4];
    logic signed [127:0] loa, hia, lob, hib;
    sin_cos(p.aang, ca, sa);
    sin_cos(p.bang, cb, sb);
    corners(p.acx, p.acy, p.ahw, p.ahh, ca, sa, kax, kay);
    corners(p.bcx, p.bcy, p.bhw, p.bhh, cb, sb, kbx, kby);
    dx[0] = ca;  dy[0] = sa;
    dx[1] = -sa; dy[1] = ca;
    dx[2] = cb;  dy[2] = sb;
    dx[3] = -sb; dy[3] = cb;
    for (int i = 0; i < 4; i++) begin
      interval(kax, kay, dx[i], dy[i], loa, hia);
      interval(kbx, kby, dx[i], dy[i], lob, hib);
      // a strict gap separates; touching still counts as overlap
      if (hia < lob || hib < loa) return 1'b0;
    end
    return 1'b1;
  endfunction

  task automatic report_mismatch(input string what);
    errors++;
    $display("mismatch at cycle %0d: %s", cyc, what);
  endtask

  // Idle with a chance of 35 in 100, except in one calm window where nothing idles.
  function automatic bit idle_now();
    if (cyc >= 1500 && cyc < 2300) return 1'b0;
    return $urandom_range(99) < 35;
  endfunction

  always @(posedge clk) cyc <= cyc + 1;

  // Driver: advance on acceptance or when idle; hold a stalled item unchanged.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (in_valid) hit_q.push_back(boxes_overlap(cur));
      if (pair_q.size() > 0 && !idle_now()) begin
        cur <= pair_q.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor: check each accepted result against the oldest prediction.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (hit_q.size() == 0) begin
          report_mismatch("result with no item outstanding");
        end else begin
          bit want;
          want = hit_q.pop_front();
          if (overlap !== want)
            report_mismatch($sformatf("overlap got %b want %b", overlap, want));
        end
      end
      out_stall <= idle_now();
    end
  end

  function automatic box_pair_t make_pair(input logic signed [31:0] acx, input logic signed [31:0] acy,
                                          input logic [31:0] ahw, input logic [31:0] ahh,
                                          input logic [15:0] aang,
                                          input logic signed [31:0] bcx, input logic signed [31:0] bcy,
                                          input logic [31:0] bhw, input logic [31:0] bhh,
                                          input logic [15:0] bang);
    box_pair_t p;
    p.acx = acx; p.acy = acy; p.ahw = 31'(ahw); p.ahh = 31'(ahh); p.aang = aang;
    p.bcx = bcx; p.bcy = bcy; p.bhw = 31'(bhw); p.bhh = 31'(bhh); p.bang = bang;
    return p;
  endfunction

  function automatic logic signed [31:0] near_coord();
    return $signed(32'($urandom_range(32'h0040_0000))) - 32'sh0020_0000;
  endfunction

  initial begin
    box_pair_t p;
    int mode;
    localparam logic signed [31:0] ONE = 32'sh0001_0000;
    localparam logic signed [31:0] CMAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] CMIN = 32'sh8000_0000;
    localparam logic [31:0] HMAX = 32'h7FFF_FFFF;

    // directed: degenerate points, extremes, quadrant angles, touching edges
    pair_q.push_back(make_pair(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    pair_q.push_back(make_pair(0, 0, 0, 0, 0, 1, 0, 0, 0, 0));
    pair_q.push_back(make_pair(CMAX, CMAX, HMAX, HMAX, 16'hFFFF,
                               CMIN, CMIN, HMAX, HMAX, 16'h0000));
    pair_q.push_back(make_pair(CMAX, CMIN, 0, 0, 16'h8000, CMIN, CMAX, 0, 0, 16'h4000));
    pair_q.push_back(make_pair(CMIN, CMIN, HMAX, 0, 16'hC000, CMAX, CMAX, 0, HMAX, 16'h2000));
    pair_q.push_back(make_pair(0, 0, ONE, ONE, 0, 2 * ONE, 0, ONE, ONE, 0));
    pair_q.push_back(make_pair(0, 0, ONE, ONE, 0, 2 * ONE + 1, 0, ONE, ONE, 0));
    pair_q.push_back(make_pair(0, 0, ONE, ONE, 0, 2 * ONE - 1, 0, ONE, ONE, 0));
    pair_q.push_back(make_pair(0, 0, ONE, ONE, 0, 0, 2 * ONE, ONE, ONE, 16'h4000));
    pair_q.push_back(make_pair(0, 0, ONE, ONE, 16'h8000, 0, -2 * ONE, ONE, ONE, 16'hC000));
    pair_q.push_back(make_pair(0, 0, ONE, ONE, 16'h2000, 3 * ONE, 0, ONE, ONE, 16'h2000));
    pair_q.push_back(make_pair(0, 0, ONE, ONE, 16'h2000, 2 * ONE, 2 * ONE, ONE, ONE, 0));
    pair_q.push_back(make_pair(0, 0, HMAX, HMAX, 16'h1234, 0, 0, 0, 0, 16'hFFFF));
    pair_q.push_back(make_pair(5 * ONE, 0, 3 * ONE, ONE, 16'h0001,
                               -5 * ONE, 0, 3 * ONE, ONE, 16'h7FFF));
    pair_q.push_back(make_pair(0, 0, 4 * ONE, ONE / 4, 16'h2000,
                               3 * ONE, 0, ONE / 4, 4 * ONE, 16'hE000));

    // random: mostly nearby boxes so both outcomes show up, some fully random
    repeat (800) begin
      mode = $urandom_range(9);
      p.aang = 16'($urandom); p.bang = 16'($urandom);
      if (mode < 5) begin
        p.acx = near_coord(); p.acy = near_coord();
        p.bcx = near_coord(); p.bcy = near_coord();
        p.ahw = 31'($urandom_range(32'h0020_0000)); p.ahh = 31'($urandom_range(32'h0020_0000));
        p.bhw = 31'($urandom_range(32'h0020_0000)); p.bhh = 31'($urandom_range(32'h0020_0000));
      end else if (mode < 8) begin
        p.acx = $signed($urandom); p.acy = $signed($urandom);
        p.bcx = p.acx + (near_coord() <<< 8); p.bcy = p.acy + (near_coord() <<< 8);
        p.ahw = 31'($urandom) >> 4; p.ahh = 31'($urandom) >> 4;
        p.bhw = 31'($urandom) >> 4; p.bhh = 31'($urandom) >> 4;
      end else begin
        p.acx = $signed($urandom); p.acy = $signed($urandom);
        p.bcx = $signed($urandom); p.bcy = $signed($urandom);
        p.ahw = 31'($urandom); p.ahh = 31'($urandom);
        p.bhw = 31'($urandom); p.bhh = 31'($urandom);
      end
      pair_q.push_back(p);
    end

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // drain: wait until every item is sent and every result is back
    while (pair_q.size() > 0 || in_valid || hit_q.size() > 0) @(posedge clk);
    repeat (obbsat_pkg::CORDIC_STEPS + 20) @(posedge clk);
    if (errors == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    #2ms;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/obbsat_pkg.sv
hdl/obbsat_cordic.sv
hdl/obb2d_sat_intersect.sv
bench/obb2d_sat_intersect_tb.sv
